// ----- sv/ofe_pkg.sv -----
// shared types and constants for the offset base64 frame encoder
// used by every module of the block, no dependencies
package ofe_pkg;

  localparam int ADDR_W      = 5;
  localparam int SUM_W       = 12;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_A    = 8'h61;
  localparam logic [7:0] CH_EQ   = 8'h3d;
  localparam logic [7:0] CH_CR   = 8'h0d;

  // one unit of work for the character sequencer
  typedef struct packed {
    logic        hdr;       // send '#', address, command
    logic [7:0]  cmd;
    logic        grp;       // send one group of four characters
    logic [23:0] grp_bits;  // three bytes, first byte in the top bits
    logic        trl;       // send checksum and carriage return
  } job_t;

  typedef enum logic [1:0] {
    PH_HDR,
    PH_GRP,
    PH_TRL
  } ph_t;

endpackage

// ----- sv/offset_base64_frame_encoder_core.sv -----
// top level of the offset base64 frame encoder
// depends on ofe_pkg, ofe_front, ofe_queue, ofe_back
//
// channel   dir  handshake           payload
// s_*       in   s_tvalid/s_tready   tdata{data_byte, command}, tuser has_data, tlast last_byte
// m_*       out  m_tvalid/m_tready   tdata out_char, tlast frame_end, tuser run_last
// cfg_*     in   cfg_wen             cfg_wdata frame_address
//
// the back end sends one character per cycle unless the output stalls; a word
// causes 0 to 10 characters, about 4/3 per payload byte
// words that cause no character never enter the queue
// the front end accepts a word every cycle while the job queue has room
// output stalls fill the queue and then drop s_tready
// rst clears frame state, queue and output valid; frame_address resets to 0
module offset_base64_frame_encoder_core #(
  parameter int QUEUE_DEPTH = ofe_pkg::QUEUE_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [15:0]                s_tdata,   // command, data_byte
  input  logic                       s_tuser,   // has_data
  input  logic                       s_tlast,   // last_byte
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [7:0]                 m_tdata,   // out_char
  output logic                       m_tuser,   // run_last
  output logic                       m_tlast,   // frame_end
  input  logic                       cfg_wen,
  input  logic [ofe_pkg::ADDR_W-1:0] cfg_wdata
);

  logic [ofe_pkg::ADDR_W-1:0] frame_address;
  logic          q_full;
  logic          acc;
  logic          push;
  ofe_pkg::job_t push_job;
  logic          head_valid;
  ofe_pkg::job_t head_job;
  logic          pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_address <= '0;
    end else if (cfg_wen) begin
      frame_address <= cfg_wdata;
    end
  end

  assign s_tready = !q_full;
  assign acc      = s_tvalid && s_tready;

  ofe_front u_front (
    .clk       (clk),
    .rst       (rst),
    .acc       (acc),
    .command   (s_tdata[7:0]),
    .data_byte (s_tdata[15:8]),
    .has_data  (s_tuser),
    .last_byte (s_tlast),
    .push      (push),
    .job       (push_job)
  );

  ofe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  ofe_back u_back (
    .clk           (clk),
    .rst           (rst),
    .frame_address (frame_address),
    .head_valid    (head_valid),
    .head_job      (head_job),
    .pop           (pop),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tlast       (m_tlast),
    .m_tuser       (m_tuser)
  );

endmodule

// ----- sv/ofe_front.sv -----
// front end: accepts input words, tracks the frame and groups bytes into jobs
// depends on ofe_pkg
module ofe_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             acc,
  input  logic [7:0]       command,
  input  logic [7:0]       data_byte,
  input  logic             has_data,
  input  logic             last_byte,
  output logic             push,
  output ofe_pkg::job_t    job
);

  logic       in_frame;
  logic [1:0] phase;
  logic [7:0] held_hi;
  logic [7:0] held_lo;

  logic [1:0] phase_mid;
  logic [7:0] hi_mid;
  logic [7:0] lo_mid;
  logic       full_grp;

  always_comb begin
    phase_mid = phase;
    hi_mid    = held_hi;
    lo_mid    = held_lo;
    full_grp  = 1'b0;
    if (has_data) begin
      case (phase)
        2'd0: begin
          hi_mid    = data_byte;
          phase_mid = 2'd1;
        end
        2'd1: begin
          lo_mid    = data_byte;
          phase_mid = 2'd2;
        end
        default: begin
          full_grp  = 1'b1;
          phase_mid = 2'd0;
        end
      endcase
    end

    job.hdr = !in_frame;
    job.cmd = command;
    job.trl = last_byte;
    job.grp = full_grp;
    job.grp_bits = {held_hi, held_lo, data_byte};
    // a partial group at frame end is zero padded
    if (!full_grp && last_byte) begin
      case (phase_mid)
        2'd1: begin
          job.grp      = 1'b1;
          job.grp_bits = {hi_mid, 16'h0000};
        end
        2'd2: begin
          job.grp      = 1'b1;
          job.grp_bits = {hi_mid, lo_mid, 8'h00};
        end
        default: begin
          job.grp = 1'b0;
        end
      endcase
    end
    push = acc && (job.hdr || job.grp || job.trl);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame <= 1'b0;
      phase    <= 2'd0;
    end else if (acc) begin
      if (last_byte) begin
        in_frame <= 1'b0;
        phase    <= 2'd0;
      end else begin
        in_frame <= 1'b1;
        phase    <= phase_mid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      held_hi <= last_byte ? 8'h00 : hi_mid;
      held_lo <= last_byte ? 8'h00 : lo_mid;
    end
  end

endmodule

// ----- sv/ofe_queue.sv -----
// small job queue between the front end and the character sequencer
// depends on ofe_pkg
module ofe_queue #(
  parameter int DEPTH = ofe_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  ofe_pkg::job_t   push_job,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output ofe_pkg::job_t   head_job
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  ofe_pkg::job_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head_job   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- sv/ofe_back.sv -----
// back end: walks each job one character per cycle unless the output stalls,
// keeps the running checksum and drives the output register; depends on ofe_pkg
module ofe_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [ofe_pkg::ADDR_W-1:0] frame_address,
  input  logic                       head_valid,
  input  ofe_pkg::job_t              head_job,
  output logic                       pop,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [7:0]                 m_tdata,
  output logic                       m_tlast,
  output logic                       m_tuser
);

  ofe_pkg::ph_t ph, ph_next, cur_ph;
  logic [1:0] idx, idx_next, cur_idx;
  logic       busy, busy_next;
  logic [ofe_pkg::SUM_W-1:0] char_sum, char_sum_next;

  logic       emit;
  logic [7:0] ch;
  logic [5:0] six;
  logic       fe;
  logic       ph_end;
  logic       done;

  always_ff @(posedge clk) begin
    if (rst) begin
      ph       <= ofe_pkg::PH_HDR;
      idx      <= 2'd0;
      busy     <= 1'b0;
      char_sum <= '0;
    end else begin
      ph       <= ph_next;
      idx      <= idx_next;
      busy     <= busy_next;
      char_sum <= char_sum_next;
    end
  end

  always_comb begin
    emit = head_valid && (!m_tvalid || m_tready);
    if (busy) begin
      cur_ph  = ph;
      cur_idx = idx;
    end else begin
      cur_ph  = head_job.hdr ? ofe_pkg::PH_HDR :
                head_job.grp ? ofe_pkg::PH_GRP : ofe_pkg::PH_TRL;
      cur_idx = 2'd0;
    end

    case (cur_idx)
      2'd0:    six = head_job.grp_bits[23:18];
      2'd1:    six = head_job.grp_bits[17:12];
      2'd2:    six = head_job.grp_bits[11:6];
      default: six = head_job.grp_bits[5:0];
    endcase

    fe     = 1'b0;
    ph_end = 1'b0;
    case (cur_ph)
      ofe_pkg::PH_HDR: begin
        ph_end = (cur_idx == 2'd2);
        case (cur_idx)
          2'd0:    ch = ofe_pkg::CH_HASH;
          2'd1:    ch = ofe_pkg::CH_A + {3'b000, frame_address};
          default: ch = head_job.cmd;
        endcase
      end
      ofe_pkg::PH_GRP: begin
        ph_end = (cur_idx == 2'd3);
        ch     = ofe_pkg::CH_EQ + {2'b00, six};
      end
      default: begin
        ph_end = (cur_idx == 2'd2);
        case (cur_idx)
          2'd0:    ch = ofe_pkg::CH_EQ + {2'b00, char_sum[11:6]};
          2'd1:    ch = ofe_pkg::CH_EQ + {2'b00, char_sum[5:0]};
          default: begin
            ch = ofe_pkg::CH_CR;
            fe = 1'b1;
          end
        endcase
      end
    endcase

    // update the checksum, then pick the next phase of this job, or finish it
    ph_next   = ph;
    idx_next  = idx;
    busy_next = busy;
    done      = 1'b0;
    char_sum_next = char_sum;
    if (emit) begin
      case (cur_ph)
        ofe_pkg::PH_HDR: begin
          if (cur_idx == 2'd0) begin
            char_sum_next = {4'h0, ch};
          end else begin
            char_sum_next = char_sum + {4'h0, ch};
          end
        end
        ofe_pkg::PH_GRP: char_sum_next = char_sum + {4'h0, ch};
        default:         char_sum_next = char_sum;
      endcase

      if (!ph_end) begin
        ph_next   = cur_ph;
        idx_next  = cur_idx + 2'd1;
        busy_next = 1'b1;
      end else begin
        idx_next = 2'd0;
        case (cur_ph)
          ofe_pkg::PH_HDR: begin
            if (head_job.grp) begin
              ph_next   = ofe_pkg::PH_GRP;
              busy_next = 1'b1;
            end else if (head_job.trl) begin
              ph_next   = ofe_pkg::PH_TRL;
              busy_next = 1'b1;
            end else begin
              done = 1'b1;
            end
          end
          ofe_pkg::PH_GRP: begin
            if (head_job.trl) begin
              ph_next   = ofe_pkg::PH_TRL;
              busy_next = 1'b1;
            end else begin
              done = 1'b1;
            end
          end
          default: done = 1'b1;
        endcase
        if (done) begin
          busy_next = 1'b0;
        end
      end
    end
    pop = emit && done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata <= ch;
      m_tlast <= fe;
      m_tuser <= done;
    end
  end

  // the carriage return always closes its word's run
  a_cr_ends_run: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tuser)
    else $error("frame end without run end");

  // a job in progress stays at the queue head
  a_busy_head: assert property (@(posedge clk) disable iff (rst)
    busy |-> head_valid)
    else $error("sequencer busy with empty queue");

  // popping a job puts its last character on the output
  a_pop_marks: assert property (@(posedge clk) disable iff (rst)
    pop |=> m_tvalid && m_tuser)
    else $error("job finished without run end mark");

  // checksum characters are never emitted mid job without a trailer request
  a_trl_job: assert property (@(posedge clk) disable iff (rst)
    emit && cur_ph == ofe_pkg::PH_TRL |-> head_job.trl)
    else $error("trailer emitted for job without frame end");

endmodule
